FILE: hdl/rectangle_fingerprint_hash_defines.svh
// Assertion macros shared by the rectangle fingerprint hash RTL.
`ifndef RECTANGLE_FINGERPRINT_HASH_DEFINES_SVH
`define RECTANGLE_FINGERPRINT_HASH_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RFH_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rectangle_fingerprint_hash: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RFH_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rectangle_fingerprint_hash: assertion failed");

`endif

FILE: hdl/rfh_pkg.sv
// Package with types and constants of the rectangle fingerprint hash.
`timescale 1ns / 1ps
`default_nettype none
package rfh_pkg;

  localparam int FW_W        = 14;
  localparam int FH_W        = 14;
  localparam int RS_W        = 18;
  localparam int CFG_DATA_W  = 18;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_STRIDE   = 2'd2;

  localparam int RFH_BYTES_PER_PIXEL = 4;
  localparam int RFH_QUEUE_DEPTH     = 2;

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] MIX_MUL_A = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_MUL_B = 64'hc4ceb9fe1a85ec53;
  localparam int          MIX_SHIFT = 33;

  typedef struct packed {
    logic [7:0]         byte_value;
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic [15:0]        rect_width;
    logic [15:0]        rect_height;
    logic               last_byte;
  } rfh_in_t;

  typedef struct packed {
    logic [63:0] fingerprint;
    logic        fingerprint_ok;
  } rfh_out_t;

  // One finished rectangle handed from the front to the mixer.
  typedef struct packed {
    logic [63:0] mix_in;
    logic        ok;
  } rfh_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rfh_q_status_t;

endpackage
`default_nettype wire

FILE: hdl/rfh_front.sv
// Front end: configuration registers, FNV-1a byte folding and bounds check.
`timescale 1ns / 1ps
`default_nettype none
module rfh_front
  import rfh_pkg::*;
#(
  parameter int BYTES_PER_PIXEL = RFH_BYTES_PER_PIXEL
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   push,
  input  wire rfh_in_t                item,
  input  wire rfh_q_status_t          q_status,
  output logic                        full,
  output logic                        q_push,
  output rfh_job_t                    q_job
);

  localparam int BPP_W  = $clog2(BYTES_PER_PIXEL + 1);
  localparam int SPAN_W = FW_W + BPP_W;
  localparam int CMP_W  = (SPAN_W > RS_W) ? SPAN_W : RS_W;

  logic [FW_W-1:0]   frame_width;
  logic [FH_W-1:0]   frame_height;
  logic [RS_W-1:0]   row_stride;
  logic [63:0]       running_hash;
  logic [63:0]       folded;
  logic [63:0]       xb;
  logic              accept;
  logic              has_area;
  logic              valid;
  logic [14:0]       x_pos;
  logic [14:0]       y_pos;
  logic [16:0]       x_end;
  logic [16:0]       y_end;
  logic [SPAN_W-1:0] row_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= '0;
      frame_height <= '0;
      row_stride   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
        CFG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        CFG_ROW_STRIDE:   row_stride   <= cfg_data[RS_W-1:0];
        default: ;
      endcase
    end
  end

  assign full     = q_status.full;
  assign accept   = push && !q_status.full;
  assign has_area = (item.rect_width != 16'd0) && (item.rect_height != 16'd0);

  // The FNV prime is 2^40 + 0x1b3, so the multiply is a handful of shifted adds.
  assign xb = running_hash ^ {56'd0, item.byte_value};
  always_comb begin
    if (has_area) begin
      folded = (xb << 40) + (xb << 8) + (xb << 7) + (xb << 5) + (xb << 4) + (xb << 1) + xb;
    end else begin
      folded = running_hash;
    end
  end

  assign x_pos     = item.rect_x[14:0];
  assign y_pos     = item.rect_y[14:0];
  assign x_end     = {2'b00, x_pos} + {1'b0, item.rect_width};
  assign y_end     = {2'b00, y_pos} + {1'b0, item.rect_height};
  assign row_bytes = SPAN_W'(frame_width) * SPAN_W'(BYTES_PER_PIXEL);

  // With the origin inside the frame, origin plus extent bounded by the frame
  // size is the same test as extent bounded by the space left.
  assign valid = (frame_width != '0) && (frame_height != '0)
              && !item.rect_x[15] && !item.rect_y[15] && has_area
              && (x_pos <= {1'b0, frame_width}) && (y_pos <= {1'b0, frame_height})
              && (x_end <= {3'b000, frame_width}) && (y_end <= {3'b000, frame_height})
              && (CMP_W'(row_bytes) <= CMP_W'(row_stride));

  assign q_push       = accept && item.last_byte;
  assign q_job.mix_in = folded ^ {16'd0, item.rect_width, 16'd0, item.rect_height};
  assign q_job.ok     = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= FNV_BASIS;
    end else if (accept) begin
      running_hash <= item.last_byte ? FNV_BASIS : folded;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/rfh_queue.sv
// Short queue of finished rectangles between the front end and the mixer.
`timescale 1ns / 1ps
`default_nettype none
module rfh_queue
  import rfh_pkg::*;
#(
  parameter int DEPTH = RFH_QUEUE_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire rfh_job_t  push_job,
  input  wire logic      pop,
  output rfh_job_t       head_job,
  output rfh_q_status_t  status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rfh_job_t         entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_job     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/rfh_back.sv
// Back end: fmix64 finalizer on a shared 32x32 multiplier and the result register.
`timescale 1ns / 1ps
`default_nettype none
module rfh_back
  import rfh_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire rfh_q_status_t q_status,
  input  wire rfh_job_t      head_job,
  output logic               q_pop,
  input  wire logic          pop,
  output logic               empty,
  output rfh_out_t           result
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LL   = 3'd1;
  localparam logic [2:0] S_HL   = 3'd2;
  localparam logic [2:0] S_LH   = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]  state;
  logic        phase;
  logic [63:0] value;
  logic        ok;
  logic [63:0] acc;
  logic [63:0] mul_const;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] prod;
  logic [63:0] prod_hi;
  logic [63:0] mix_sum;
  logic        out_full;
  logic        out_free;

  // Low 64 bits of a 64x64 product: low*low plus both cross terms shifted up.
  assign mul_const = phase ? MIX_MUL_B : MIX_MUL_A;
  always_comb begin
    unique case (state)
      S_HL: begin
        op_a = value[63:32];
        op_b = mul_const[31:0];
      end
      S_LH: begin
        op_a = value[31:0];
        op_b = mul_const[63:32];
      end
      default: begin
        op_a = value[31:0];
        op_b = mul_const[31:0];
      end
    endcase
  end

  assign prod    = {32'd0, op_a} * {32'd0, op_b};
  assign prod_hi = {prod[31:0], 32'd0};
  assign mix_sum = acc + prod_hi;

  assign empty    = !out_full;
  assign out_free = !out_full || pop;
  assign q_pop    = (state == S_IDLE) && !q_status.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!q_status.empty) begin
            state <= S_LL;
            phase <= 1'b0;
          end
        end
        S_LL: state <= S_HL;
        S_HL: state <= S_LH;
        S_LH: begin
          if (phase) begin
            state <= S_DONE;
          end else begin
            phase <= 1'b1;
            state <= S_LL;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        value <= head_job.mix_in ^ (head_job.mix_in >> MIX_SHIFT);
        ok    <= head_job.ok;
      end
      S_LL: acc <= prod;
      S_HL: acc <= mix_sum;
      S_LH: value <= mix_sum ^ (mix_sum >> MIX_SHIFT);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_full <= 1'b1;
    end else if (pop) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      result.fingerprint    <= ok ? value : 64'd0;
      result.fingerprint_ok <= ok;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/rectangle_fingerprint_hash.sv
// Top level of the rectangle fingerprint hash: front end, job queue and mixer.
//
// Pixel bytes are taken one per clock cycle and folded into an FNV-1a hash by
// shift-and-add logic in the front end. The byte marked last also runs the
// bounds check and drops the finished rectangle into a queue of QUEUE_DEPTH
// entries; full rises only while that queue is full, and then every input
// transaction waits, not only last bytes. The mixer takes one rectangle at a
// time: it loads the job, runs each of the two fmix64 multiplies as low-low,
// high-low and low-high partial products on its single 32x32 multiplier, and
// writes the result register, which holds the fingerprint until it is popped.
// While that register still holds an unpopped fingerprint, the mixer waits in
// its done state. The queue fills, and the input stalls, only when rectangles
// keep ending faster than the mixer finishes them or results are not popped.
// Configuration writes are registered before the bounds check uses them.
`timescale 1ns / 1ps
`default_nettype none
`include "rectangle_fingerprint_hash_defines.svh"
module rectangle_fingerprint_hash
  import rfh_pkg::*;
#(
  parameter int BYTES_PER_PIXEL = RFH_BYTES_PER_PIXEL,
  parameter int QUEUE_DEPTH     = RFH_QUEUE_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   push,
  output logic                        full,
  input  wire rfh_in_t                item,
  output logic                        empty,
  input  wire logic                   pop,
  output rfh_out_t                    result
);

  rfh_q_status_t q_status;
  rfh_job_t      push_job;
  rfh_job_t      head_job;
  logic          q_push;
  logic          q_pop;

  rfh_front #(
    .BYTES_PER_PIXEL(BYTES_PER_PIXEL)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .push     (push),
    .item     (item),
    .q_status (q_status),
    .full     (full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  rfh_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_job(push_job),
    .pop     (q_pop),
    .head_job(head_job),
    .status  (q_status)
  );

  rfh_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_status(q_status),
    .head_job(head_job),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

  // A rectangle that ends on an accepted transaction is waiting in the queue next cycle.
  `RFH_ASSERT_NEXT(a_last_enqueued, clk, rst, push && !full && item.last_byte, !q_status.empty)
  // The mixer only takes a job that is really there.
  `RFH_ASSERT_NOW(a_pop_nonempty, clk, rst, q_pop, !q_status.empty)
  // A rejected rectangle always reports a zero fingerprint.
  `RFH_ASSERT_NOW(a_bad_is_zero, clk, rst, !empty && !result.fingerprint_ok, result.fingerprint == 64'd0)

endmodule
`default_nettype wire
